// File: rtl/crd_pkg.sv
// Shared types and constants for the checked record decoder.
// Used by crd_core and the top level; no dependencies.
package crd_pkg;

  // Record layout: byte positions within the 12-byte record
  localparam logic [3:0] POS_HEAD   = 4'd0;
  localparam logic [3:0] POS_VER    = 4'd1;
  localparam logic [3:0] POS_CNT0   = 4'd2;
  localparam logic [3:0] POS_CNT1   = 4'd3;
  localparam logic [3:0] POS_CNT2   = 4'd4;
  localparam logic [3:0] POS_CNT3   = 4'd5;
  localparam logic [3:0] POS_RLX_LO = 4'd6;
  localparam logic [3:0] POS_RLX_HI = 4'd7;
  localparam logic [3:0] POS_DSH_LO = 4'd8;
  localparam logic [3:0] POS_DSH_HI = 4'd9;
  localparam logic [3:0] POS_CHK_LO = 4'd10;
  localparam logic [3:0] POS_LAST   = 4'd11;
  localparam logic [3:0] SUM_LEN    = 4'd10;

  localparam logic [7:0] REC_MAGIC   = 8'h4A;
  localparam logic [7:0] REC_VERSION = 8'h01;
  localparam logic [8:0] FL_MOD      = 9'd255;

  typedef enum logic [1:0] {
    STAT_OK         = 2'd0,
    STAT_BAD_HEADER = 2'd1,
    STAT_BAD_SUM    = 2'd2
  } status_e;

  typedef struct packed {
    status_e     status;
    logic [31:0] clear_count;
    logic [15:0] relaxed_score;
    logic [15:0] dash_score;
  } result_t;

endpackage

// File: rtl/crd_rec_if.sv
// Input channel of the checked record decoder: one record byte per item.
// Stand-alone valid/ready interface; no dependencies.
interface crd_rec_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       restart;

  modport source (output valid, output data_byte, output restart, input ready);
  modport sink (input valid, input data_byte, input restart, output ready);
endinterface

// File: rtl/crd_res_if.sv
// Result channel of the checked record decoder: status and decoded fields.
// Stand-alone valid/ready interface; no dependencies.
interface crd_res_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [31:0] clear_count;
  logic [15:0] relaxed_score;
  logic [15:0] dash_score;

  modport source (output valid, output status, output clear_count,
                  output relaxed_score, output dash_score, input ready);
  modport sink (input valid, input status, input clear_count,
                input relaxed_score, input dash_score, output ready);
endinterface

// File: rtl/crd_core.sv
// Record state of the decoder: byte position, Fletcher-16 sums, header
// checks and field capture. Depends on crd_pkg.
module crd_core (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             step_i,
  input  logic [7:0]       data_byte_i,
  input  logic             restart_i,
  output logic             last_o,
  output crd_pkg::result_t result_o
);

  logic [3:0]  pos_q, pos_d, pos_eff;
  logic [7:0]  sum_low_q, sum_low_d;
  logic [7:0]  sum_high_q, sum_high_d;
  logic        header_good_q, header_good_d;
  logic        check_low_good_q, check_low_good_d;
  logic [31:0] cleared_q, cleared_d;
  logic [15:0] relaxed_q, relaxed_d;
  logic [15:0] dash_q, dash_d;

  logic [7:0]  sum_low_base, sum_high_base;
  logic [8:0]  lo_sum, lo_mod, hi_sum, hi_mod;
  crd_pkg::status_e status;

  // Restart, or an out-of-range position, forces byte 0
  assign pos_eff = (restart_i || pos_q > crd_pkg::POS_LAST) ? crd_pkg::POS_HEAD : pos_q;
  assign last_o  = (pos_eff == crd_pkg::POS_LAST);

  // Byte 0 starts both sums from zero
  assign sum_low_base  = (pos_eff == crd_pkg::POS_HEAD) ? 8'd0 : sum_low_q;
  assign sum_high_base = (pos_eff == crd_pkg::POS_HEAD) ? 8'd0 : sum_high_q;

  // Mod-255 accumulators: each sum stays below twice the modulus
  assign lo_sum = {1'b0, sum_low_base} + {1'b0, data_byte_i};
  assign lo_mod = (lo_sum >= crd_pkg::FL_MOD) ? lo_sum - crd_pkg::FL_MOD : lo_sum;
  assign hi_sum = {1'b0, sum_high_base} + lo_mod;
  assign hi_mod = (hi_sum >= crd_pkg::FL_MOD) ? hi_sum - crd_pkg::FL_MOD : hi_sum;

  always_comb begin
    pos_d            = last_o ? crd_pkg::POS_HEAD : pos_eff + 4'd1;
    sum_low_d        = sum_low_q;
    sum_high_d       = sum_high_q;
    header_good_d    = header_good_q;
    check_low_good_d = check_low_good_q;
    cleared_d        = cleared_q;
    relaxed_d        = relaxed_q;
    dash_d           = dash_q;

    if (pos_eff < crd_pkg::SUM_LEN) begin
      sum_low_d  = lo_mod[7:0];
      sum_high_d = hi_mod[7:0];
    end

    unique case (pos_eff)
      crd_pkg::POS_HEAD: begin
        // First byte clears the captured fields
        header_good_d    = (data_byte_i == crd_pkg::REC_MAGIC);
        check_low_good_d = 1'b0;
        cleared_d        = '0;
        relaxed_d        = '0;
        dash_d           = '0;
      end
      crd_pkg::POS_VER:    header_good_d = header_good_q && (data_byte_i == crd_pkg::REC_VERSION);
      crd_pkg::POS_CNT0:   cleared_d[7:0]   = data_byte_i;
      crd_pkg::POS_CNT1:   cleared_d[15:8]  = data_byte_i;
      crd_pkg::POS_CNT2:   cleared_d[23:16] = data_byte_i;
      crd_pkg::POS_CNT3:   cleared_d[31:24] = data_byte_i;
      crd_pkg::POS_RLX_LO: relaxed_d[7:0]   = data_byte_i;
      crd_pkg::POS_RLX_HI: relaxed_d[15:8]  = data_byte_i;
      crd_pkg::POS_DSH_LO: dash_d[7:0]      = data_byte_i;
      crd_pkg::POS_DSH_HI: dash_d[15:8]     = data_byte_i;
      crd_pkg::POS_CHK_LO: check_low_good_d = (data_byte_i == sum_low_q);
      default: ;
    endcase
  end

  // Bad header wins over a checksum mismatch
  always_comb begin
    if (!header_good_q) begin
      status = crd_pkg::STAT_BAD_HEADER;
    end else if (check_low_good_q && data_byte_i == sum_high_q) begin
      status = crd_pkg::STAT_OK;
    end else begin
      status = crd_pkg::STAT_BAD_SUM;
    end
  end

  always_comb begin
    result_o.status        = status;
    result_o.clear_count   = (status == crd_pkg::STAT_OK) ? cleared_q : '0;
    result_o.relaxed_score = (status == crd_pkg::STAT_OK) ? relaxed_q : '0;
    result_o.dash_score    = (status == crd_pkg::STAT_OK) ? dash_q : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q            <= crd_pkg::POS_HEAD;
      sum_low_q        <= '0;
      sum_high_q       <= '0;
      header_good_q    <= 1'b1;
      check_low_good_q <= 1'b0;
      cleared_q        <= '0;
      relaxed_q        <= '0;
      dash_q           <= '0;
    end else if (step_i) begin
      pos_q            <= pos_d;
      sum_low_q        <= sum_low_d;
      sum_high_q       <= sum_high_d;
      header_good_q    <= header_good_d;
      check_low_good_q <= check_low_good_d;
      cleared_q        <= cleared_d;
      relaxed_q        <= relaxed_d;
      dash_q           <= dash_d;
    end
  end

endmodule

// File: rtl/checked_record_decoder.sv
// Checked record decoder: validates and unpacks 12-byte progress records.
// Depends on crd_pkg, crd_rec_if, crd_res_if and crd_core.
//
// Usage:
//   rec_i carries one record byte per item, with a restart flag that marks
//   the byte as byte 0 and drops any partial record. res_o carries one item
//   per record: status (0 valid, 1 bad magic or version, 2 checksum
//   mismatch) and the little-endian cleared count and two best scores,
//   which read as zero unless the status is valid.
//   Throughput: one byte per cycle, sustained while the result register is
//   free for each twelfth byte. Each byte sits in the input register while
//   the record state and the two mod-255 sums are updated. The result
//   register loads as the twelfth byte leaves the input register, and res_o
//   then offers the result.
//   Without restart, the byte after the twelfth starts a new record.
//   When res_o stalls with a result waiting, the input register still takes
//   and processes bytes until the next twelfth byte, which holds there until
//   the result register frees; rec_i.ready then drops.
//   Reset: asynchronous, clears the pipeline and the byte position to 0.
module checked_record_decoder (
  input  logic      clk_i,
  input  logic      rst_ni,
  crd_rec_if.sink   rec_i,
  crd_res_if.source res_o
);

  logic             s1_valid_q;
  logic [7:0]       s1_byte_q;
  logic             s1_restart_q;
  logic             s1_adv;
  logic             core_last;
  crd_pkg::result_t core_result;

  logic             out_valid_q;
  crd_pkg::result_t out_q;
  logic             out_free;

  assign out_free    = !out_valid_q || res_o.ready;
  // Only the last byte of a record needs room in the result register
  assign s1_adv      = s1_valid_q && (!core_last || out_free);
  assign rec_i.ready = !s1_valid_q || s1_adv;

  crd_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (s1_adv),
    .data_byte_i (s1_byte_q),
    .restart_i   (s1_restart_q),
    .last_o      (core_last),
    .result_o    (core_result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (rec_i.ready) begin
      s1_valid_q <= rec_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rec_i.ready && rec_i.valid) begin
      s1_byte_q    <= rec_i.data_byte;
      s1_restart_q <= rec_i.restart;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= s1_adv && core_last;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv && core_last) begin
      out_q <= core_result;
    end
  end

  assign res_o.valid         = out_valid_q;
  assign res_o.status        = out_q.status;
  assign res_o.clear_count   = out_q.clear_count;
  assign res_o.relaxed_score = out_q.relaxed_score;
  assign res_o.dash_score    = out_q.dash_score;

`ifndef NO_ASSERTIONS
  // A new result comes only from a record's last byte leaving the input stage
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(s1_adv && core_last))
    else $error("result raised without a completed record");

  // The input stage stalls only on a last byte
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !s1_adv) |-> core_last)
    else $error("input stage stalled on a byte that gives no result");

  // A rejected record carries zeroed fields
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.status != crd_pkg::STAT_OK) |->
      (out_q.clear_count == '0 && out_q.relaxed_score == '0 && out_q.dash_score == '0))
    else $error("rejected record with non-zero fields");

  // A waiting result is not overwritten
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !res_o.ready) |=> (out_valid_q && $stable(out_q)))
    else $error("stalled result lost or changed");
`endif

endmodule
